// File: sv/gfp_pkg.sv
// Gaze frame parser package: sizes, codes, result and push types.
// Used by the interfaces, the core, the result buffer and the top level.
package gfp_pkg;

    localparam int HEADER_BYTES  = 16;
    localparam int POINT_BYTES   = 24;
    localparam int OFF_W         = 5;
    localparam int COUNT_W       = 14;
    localparam int WORD_W        = 32;
    localparam int LONG_W        = 64;
    localparam int CFG_IDX_W     = 2;
    localparam int OUT_DEPTH_DEF = 3;

    localparam logic [OFF_W-1:0]   HDR_LAST        = OFF_W'(HEADER_BYTES - 1);
    localparam logic [OFF_W-1:0]   PT_LAST         = OFF_W'(POINT_BYTES - 1);
    localparam logic [COUNT_W-1:0] MAX_COUNT_RESET = COUNT_W'(10000);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_POINTS = 2'd1,
        PH_DONE   = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        ST_ACCEPTED    = 3'd0,
        ST_SHORT_HDR   = 3'd1,
        ST_BAD_MAGIC   = 3'd2,
        ST_BAD_VERSION = 3'd3,
        ST_SAME_SEQ    = 3'd4,
        ST_COUNT_BIG   = 3'd5,
        ST_TRUNCATED   = 3'd6
    } frame_status_t;

    typedef enum logic {
        KIND_POINT  = 1'b0,
        KIND_STATUS = 1'b1
    } result_kind_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_MAGIC     = 2'd0,
        CFG_VERSION   = 2'd1,
        CFG_MAX_COUNT = 2'd2
    } cfg_index_t;

    typedef struct packed {
        result_kind_t        kind;
        logic [COUNT_W-1:0]  point_index;
        logic [LONG_W-1:0]   timestamp;
        logic [LONG_W-1:0]   x;
        logic [LONG_W-1:0]   y;
        frame_status_t       status;
        logic [WORD_W-1:0]   count;
        logic [WORD_W-1:0]   seq;
        logic                last;
    } result_t;

    typedef struct packed {
        logic [1:0] cnt;
        result_t    first;
        result_t    second;
    } push_t;

endpackage

// File: sv/gfp_if.sv
// Channel interfaces of the gaze frame parser: byte input, result output,
// configuration write. Depends on gfp_pkg.
interface gfp_in_if import gfp_pkg::*;;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       end_of_blob;

    modport source (output valid, data_byte, end_of_blob, input ready);
    modport sink   (input valid, data_byte, end_of_blob, output ready);
endinterface

interface gfp_out_if import gfp_pkg::*;;
    logic                     valid;
    logic                     ready;
    logic                     result_kind;
    logic [COUNT_W-1:0]       point_index;
    logic signed [LONG_W-1:0] ts_ms;
    logic [LONG_W-1:0]        x_bits;
    logic [LONG_W-1:0]        y_bits;
    logic [2:0]               frame_status;
    logic [WORD_W-1:0]        point_count;
    logic [WORD_W-1:0]        sequence_number;
    logic                     last_of_run;

    modport source (output valid, result_kind, point_index, ts_ms, x_bits, y_bits,
                    frame_status, point_count, sequence_number, last_of_run,
                    input ready);
    modport sink   (input valid, result_kind, point_index, ts_ms, x_bits, y_bits,
                    frame_status, point_count, sequence_number, last_of_run,
                    output ready);
endinterface

interface gfp_cfg_if import gfp_pkg::*;;
    logic                 valid;
    logic                 ready;
    logic [CFG_IDX_W-1:0] index;
    logic [WORD_W-1:0]    data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// File: sv/gfp_core.sv
// Gaze frame parser core: config registers, header/point assembly, checks,
// frame state. Emits up to two results per accepted byte. Depends on gfp_pkg.
module gfp_core
    import gfp_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 byte_acc,
    input  logic [7:0]           data_byte,
    input  logic                 end_of_blob,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [WORD_W-1:0]    cfg_data,
    output push_t                push
);

    logic [WORD_W-1:0]  magic_reg;
    logic [WORD_W-1:0]  version_reg;
    logic [COUNT_W-1:0] max_count_reg;
    logic [WORD_W-1:0]  last_seq_reg;
    logic [WORD_W-1:0]  last_seq_next;

    phase_t             phase_reg;
    phase_t             phase_mid;
    phase_t             phase_next;
    logic [OFF_W-1:0]   off_reg;
    logic [OFF_W-1:0]   off_next;
    logic [WORD_W-1:0]  hdr_reg [4];
    logic [WORD_W-1:0]  hdr_next [4];
    logic [LONG_W-1:0]  pa_reg [3];
    logic [COUNT_W-1:0] done_cnt_reg;
    logic [COUNT_W-1:0] done_cnt_mid;
    logic [COUNT_W-1:0] done_cnt_next;
    logic [COUNT_W-1:0] done_inc;
    frame_status_t      pend_reg;
    frame_status_t      pend_mid;
    frame_status_t      pend_next;

    frame_status_t      hdr_status;
    frame_status_t      eob_status;
    logic               hdr_end;
    logic               hdr_go;
    logic               pt_end;
    logic               pt_final;
    result_t            point_res;
    result_t            status_res;

    // header bytes land in place; words not yet filled stay zero
    always_comb
    begin
        hdr_next = hdr_reg;
        if (phase_reg == PH_HEADER)
        begin
            hdr_next[off_reg[3:2]][{off_reg[1:0], 3'b000} +: 8] = data_byte;
        end
    end

    assign hdr_end  = (phase_reg == PH_HEADER) && (off_reg == HDR_LAST);
    assign pt_end   = (phase_reg == PH_POINTS) && (off_reg == PT_LAST);
    assign done_inc = done_cnt_reg + COUNT_W'(1);
    assign pt_final = pt_end && ({(WORD_W-COUNT_W)'(0), done_inc} >= hdr_next[2]);

    always_comb
    begin
        if (hdr_next[0] != magic_reg)
            hdr_status = ST_BAD_MAGIC;
        else if (hdr_next[1] != version_reg)
            hdr_status = ST_BAD_VERSION;
        else if (hdr_next[3] == last_seq_reg)
            hdr_status = ST_SAME_SEQ;
        else if (hdr_next[2] > {(WORD_W-COUNT_W)'(0), max_count_reg})
            hdr_status = ST_COUNT_BIG;
        else
            hdr_status = ST_ACCEPTED;
    end

    assign hdr_go = hdr_end && (hdr_status == ST_ACCEPTED) && (hdr_next[2] != '0);

    // next state
    always_comb
    begin
        case (phase_reg)
            PH_HEADER: phase_mid = hdr_end ? (hdr_go ? PH_POINTS : PH_DONE) : PH_HEADER;
            PH_POINTS: phase_mid = pt_final ? PH_DONE : PH_POINTS;
            default:   phase_mid = PH_DONE;
        endcase
        phase_next = end_of_blob ? PH_HEADER : phase_mid;
    end

    // datapath and results
    always_comb
    begin
        done_cnt_mid = pt_end ? done_inc : done_cnt_reg;
        if (hdr_end)
            pend_mid = hdr_status;
        else if (pt_final)
            pend_mid = ST_ACCEPTED;
        else
            pend_mid = pend_reg;

        case (phase_mid)
            PH_HEADER: eob_status = ST_SHORT_HDR;
            PH_POINTS: eob_status = ST_TRUNCATED;
            default:   eob_status = pend_mid;
        endcase

        case (phase_reg)
            PH_HEADER: off_next = hdr_end ? '0 : off_reg + OFF_W'(1);
            PH_POINTS: off_next = pt_end ? '0 : off_reg + OFF_W'(1);
            default:   off_next = off_reg;
        endcase
        if (end_of_blob)
            off_next = '0;

        done_cnt_next = end_of_blob ? '0 : done_cnt_mid;
        pend_next     = end_of_blob ? ST_ACCEPTED : pend_mid;
        last_seq_next = (end_of_blob && eob_status == ST_ACCEPTED) ? hdr_next[3] : last_seq_reg;

        point_res.kind        = KIND_POINT;
        point_res.point_index = done_cnt_reg;
        point_res.timestamp   = pa_reg[0];
        point_res.x           = pa_reg[1];
        point_res.y           = {data_byte, pa_reg[2][LONG_W-9:0]};
        point_res.status      = ST_ACCEPTED;
        point_res.count       = hdr_next[2];
        point_res.seq         = hdr_next[3];
        point_res.last        = !end_of_blob;

        status_res.kind        = KIND_STATUS;
        status_res.point_index = done_cnt_mid;
        status_res.timestamp   = '0;
        status_res.x           = '0;
        status_res.y           = '0;
        status_res.status      = eob_status;
        status_res.count       = hdr_next[2];
        status_res.seq         = hdr_next[3];
        status_res.last        = 1'b1;

        push.second = status_res;
        if (pt_end)
        begin
            push.first = point_res;
            push.cnt   = end_of_blob ? 2'd2 : 2'd1;
        end
        else
        begin
            push.first = status_res;
            push.cnt   = end_of_blob ? 2'd1 : 2'd0;
        end
        if (!byte_acc)
            push.cnt = 2'd0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            magic_reg     <= '0;
            version_reg   <= '0;
            max_count_reg <= MAX_COUNT_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_MAGIC:     magic_reg     <= cfg_data;
                CFG_VERSION:   version_reg   <= cfg_data;
                CFG_MAX_COUNT: max_count_reg <= cfg_data[COUNT_W-1:0];
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg    <= PH_HEADER;
            off_reg      <= '0;
            done_cnt_reg <= '0;
            pend_reg     <= ST_ACCEPTED;
            last_seq_reg <= '0;
            for (int i = 0; i < 4; i++)
                hdr_reg[i] <= '0;
        end
        else if (byte_acc)
        begin
            phase_reg    <= phase_next;
            off_reg      <= off_next;
            done_cnt_reg <= done_cnt_next;
            pend_reg     <= pend_next;
            last_seq_reg <= last_seq_next;
            for (int i = 0; i < 4; i++)
                hdr_reg[i] <= end_of_blob ? '0 : hdr_next[i];
        end
    end

    // every point byte is rewritten before it is read, so no clear needed
    always_ff @(posedge clk)
    begin
        if (byte_acc && phase_reg == PH_POINTS)
            pa_reg[off_reg[4:3]][{off_reg[2:0], 3'b000} +: 8] <= data_byte;
    end

endmodule

// File: sv/gfp_res_buf.sv
// Result buffer of the gaze frame parser: small FIFO taking up to two
// results per cycle and giving one. Depends on gfp_pkg.
module gfp_res_buf
    import gfp_pkg::*;
#(
    parameter int DEPTH = OUT_DEPTH_DEF
)
(
    input  logic                       clk,
    input  logic                       rst_n,
    input  push_t                      push,
    input  logic                       pop,
    output result_t                    head,
    output logic                       head_valid,
    output logic                       room,
    output logic [$clog2(DEPTH+1)-1:0] fill
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    result_t         mem_reg [DEPTH];
    logic [PW-1:0]   head_reg;
    logic [PW-1:0]   head_next;
    logic [PW-1:0]   tail_reg;
    logic [PW-1:0]   tail_next;
    logic [PW-1:0]   tail_inc;
    logic [CW-1:0]   fill_reg;
    logic [CW-1:0]   fill_next;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        return (p == PW'(DEPTH - 1)) ? '0 : p + PW'(1);
    endfunction

    assign tail_inc   = wrap_inc(tail_reg);
    assign head       = mem_reg[head_reg];
    assign head_valid = (fill_reg != '0);
    assign room       = (fill_reg <= CW'(DEPTH - 2));
    assign fill       = fill_reg;

    always_comb
    begin
        head_next = pop ? wrap_inc(head_reg) : head_reg;
        case (push.cnt)
            2'd1:    tail_next = tail_inc;
            2'd2:    tail_next = wrap_inc(tail_inc);
            default: tail_next = tail_reg;
        endcase
        fill_next = fill_reg + CW'(push.cnt) - CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            tail_reg <= '0;
            fill_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            tail_reg <= tail_next;
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push.cnt != 2'd0)
            mem_reg[tail_reg] <= push.first;
        if (push.cnt == 2'd2)
            mem_reg[tail_inc] <= push.second;
    end

endmodule

// File: sv/gaze_frame_parser.sv
// Gaze frame parser top level: channel wiring, core and result buffer.
// Depends on gfp_pkg, gfp_if, gfp_core, gfp_res_buf.
//
// One blob byte is taken per cycle while byte_ch.ready is high. Its results are
// written into an OUT_DEPTH-entry result queue (three by default) in the cycle
// it is taken and can leave the next cycle. byte_ch.ready is high while the
// queue has at least two free entries; with result_ch.ready held high this
// sustains one byte per cycle, except that a byte that both completes a point
// and ends the blob yields two results and can stall the byte channel.
// Configuration writes are always taken. Points stay tentative until the frame
// status that follows them reports acceptance.
module gaze_frame_parser
    import gfp_pkg::*;
#(
    parameter int OUT_DEPTH = OUT_DEPTH_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    gfp_in_if.sink    byte_ch,
    gfp_out_if.source result_ch,
    gfp_cfg_if.sink   cfg_ch
);

    push_t                          push;
    result_t                        head;
    logic                           head_valid;
    logic                           room;
    logic [$clog2(OUT_DEPTH+1)-1:0] fill;
    logic                           byte_acc;

    assign byte_ch.ready = room;
    assign cfg_ch.ready  = 1'b1;
    assign byte_acc      = byte_ch.valid && room;

    gfp_core u_core
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_acc    (byte_acc),
        .data_byte   (byte_ch.data_byte),
        .end_of_blob (byte_ch.end_of_blob),
        .cfg_we      (cfg_ch.valid),
        .cfg_index   (cfg_ch.index),
        .cfg_data    (cfg_ch.data),
        .push        (push)
    );

    gfp_res_buf #(.DEPTH(OUT_DEPTH)) u_res_buf
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .pop        (head_valid && result_ch.ready),
        .head       (head),
        .head_valid (head_valid),
        .room       (room),
        .fill       (fill)
    );

    assign result_ch.valid           = head_valid;
    assign result_ch.result_kind     = head.kind;
    assign result_ch.point_index     = head.point_index;
    assign result_ch.ts_ms           = head.timestamp;
    assign result_ch.x_bits          = head.x;
    assign result_ch.y_bits          = head.y;
    assign result_ch.frame_status    = head.status;
    assign result_ch.point_count     = head.count;
    assign result_ch.sequence_number = head.seq;
    assign result_ch.last_of_run     = head.last;

`ifndef SYNTH
    a_push_needs_byte: assert property (@(posedge clk) disable iff (!rst_n)
        (push.cnt != 2'd0) |-> (byte_ch.valid && byte_ch.ready))
        else $error("results pushed without an accepted byte");

    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill <= ($clog2(OUT_DEPTH+1))'(OUT_DEPTH))
        else $error("result queue overflow");

    a_eob_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
        (byte_ch.valid && byte_ch.ready && byte_ch.end_of_blob) |=> (fill != '0))
        else $error("end of blob produced no status");

    a_status_last: assert property (@(posedge clk) disable iff (!rst_n)
        (result_ch.valid && result_ch.result_kind == KIND_STATUS) |-> result_ch.last_of_run)
        else $error("frame status not marked last");
`endif

endmodule
